// ----- design/pfx_pkg.sv -----
// shared types and constants for the postfix evaluator
package pfx_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = $clog2(DataW);
  localparam int unsigned StackDepthDefault = 32;

  localparam logic [7:0] SymAdd = 8'd43;
  localparam logic [7:0] SymSub = 8'd45;
  localparam logic [7:0] SymMul = 8'd42;
  localparam logic [7:0] SymDiv = 8'd47;
  localparam logic [DataW-1:0] DigitBase = DataW'(48);

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusUnderflow = 3'd1;
  localparam logic [2:0] StatusOverflow  = 3'd2;
  localparam logic [2:0] StatusDivZero   = 3'd3;
  localparam logic [2:0] StatusLeftover  = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             start;
    op_e              op;
    logic [DataW-1:0] lhs;
    logic [DataW-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage

// ----- design/pfx_in_if.sv -----
// input channel: one expression symbol per item
interface pfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

// ----- design/pfx_out_if.sv -----
// output channel: one result item per expression
interface pfx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ----- design/pfx_serial_alu.sv -----
// digit-serial arithmetic unit: one bit of the operands per cycle
module pfx_serial_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfx_pkg::alu_req_t req_i,
  output pfx_pkg::alu_rsp_t rsp_o
);

  localparam int unsigned W = pfx_pkg::DataW;

  logic                        busy_q;
  logic                        fin_q;
  logic [pfx_pkg::StepW-1:0]   step_q;
  pfx_pkg::op_e                op_q;
  logic [W-1:0]                a_q, a_d;
  logic [W-1:0]                b_q, b_d;
  logic [W-1:0]                acc_q, acc_d;
  logic                        carry_q, carry_d;
  logic                        neg_q;

  logic                        sum_bit;
  logic                        rhs_bit;
  logic [W:0]                  shifted;
  logic [W:0]                  diff;
  logic                        fits;

  // serial add / subtract on the low bits
  assign rhs_bit = b_q[0] ^ (op_q == pfx_pkg::OP_SUB);
  assign sum_bit = a_q[0] ^ rhs_bit ^ carry_q;
  // restoring division step
  assign shifted = {acc_q, a_q[W-1]};
  assign diff    = shifted - {1'b0, b_q};
  assign fits    = ~diff[W];

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    carry_d = carry_q;
    unique case (op_q)
      pfx_pkg::OP_ADD, pfx_pkg::OP_SUB: begin
        acc_d   = {sum_bit, acc_q[W-1:1]};
        carry_d = (a_q[0] & rhs_bit) | (a_q[0] & carry_q) | (rhs_bit & carry_q);
        a_d     = a_q >> 1;
        b_d     = b_q >> 1;
      end
      pfx_pkg::OP_MUL: begin
        acc_d = acc_q + (b_q[0] ? a_q : '0);
        a_d   = a_q << 1;
        b_d   = b_q >> 1;
      end
      pfx_pkg::OP_DIV: begin
        acc_d = fits ? diff[W-1:0] : shifted[W-1:0];
        a_d   = {a_q[W-2:0], fits};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      step_q <= '0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == pfx_pkg::StepW'(W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q    <= req_i.op;
      acc_q   <= '0;
      carry_q <= (req_i.op == pfx_pkg::OP_SUB);
      neg_q   <= req_i.lhs[W-1] ^ req_i.rhs[W-1];
      if (req_i.op == pfx_pkg::OP_DIV) begin
        // magnitudes in, sign restored at the end
        a_q <= req_i.lhs[W-1] ? W'(-req_i.lhs) : req_i.lhs;
        b_q <= req_i.rhs[W-1] ? W'(-req_i.rhs) : req_i.rhs;
      end else begin
        a_q <= req_i.lhs;
        b_q <= req_i.rhs;
      end
    end else if (busy_q) begin
      a_q     <= a_d;
      b_q     <= b_d;
      acc_q   <= acc_d;
      carry_q <= carry_d;
    end
  end

  always_comb begin
    rsp_o.done = fin_q;
    if (op_q == pfx_pkg::OP_DIV) begin
      rsp_o.result = neg_q ? W'(-a_q) : a_q;
    end else begin
      rsp_o.result = acc_q;
    end
  end

endmodule

// ----- design/postfix_expression_evaluator.sv -----
// postfix expression evaluator: value stack with a digit-serial arithmetic unit
//
//   channel  | direction | payload                  | handshake
//   in_if    | sink      | symbol, last_symbol      | valid / ready
//   out_if   | source    | result_value, status     | valid / ready
//
// a pushed byte, an ignored symbol or an operator that fails its checks is taken in the idle state;
// an operator that runs goes through the bit-serial unit
// (load, 32 bit steps, write-back)
// the last item of an expression then passes through the emit state to build the result item
// rst_ni clears stack count, error and handshake state; stack memory is left as is
// a waiting result does not hold up the next expression until its own last item
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = pfx_pkg::StackDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pfx_in_if.sink       in_if,
  pfx_out_if.source    out_if
);

  localparam int unsigned W   = pfx_pkg::DataW;
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);

  // top two values in registers, the rest in memory below them
  logic [W-1:0] stack_mem [STACK_DEPTH];

  pfx_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [2:0]      err_q, err_d;
  logic [W-1:0]    tos_q, tos_d;
  logic [W-1:0]    nos_q, nos_d;
  logic [W-1:0]    rd_q;
  logic            last_q, last_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_value_q, out_value_d;
  logic [2:0]      out_status_q, out_status_d;

  logic            accept;
  logic            is_op;
  pfx_pkg::op_e    op;
  logic [W-1:0]    push_val;
  logic            start_op;
  logic            emit_now;
  logic            mem_we;
  logic            mem_re;
  logic [CW-1:0]   wr_idx;
  logic [CW-1:0]   rd_idx;

  pfx_pkg::alu_req_t alu_req;
  pfx_pkg::alu_rsp_t alu_rsp;

  assign accept = in_if.valid & in_if.ready;

  // symbol decode
  always_comb begin
    is_op = 1'b1;
    op    = pfx_pkg::OP_ADD;
    unique case (in_if.symbol)
      pfx_pkg::SymAdd: op = pfx_pkg::OP_ADD;
      pfx_pkg::SymSub: op = pfx_pkg::OP_SUB;
      pfx_pkg::SymMul: op = pfx_pkg::OP_MUL;
      pfx_pkg::SymDiv: op = pfx_pkg::OP_DIV;
      default:         is_op = 1'b0;
    endcase
  end

  assign push_val = W'(in_if.symbol) - pfx_pkg::DigitBase;

  assign start_op = accept && (err_q == pfx_pkg::StatusOk) && is_op
                 && (count_q >= CW'(2))
                 && !((op == pfx_pkg::OP_DIV) && (tos_q == '0));

  assign emit_now = (state_q == pfx_pkg::ST_EMIT) && (!out_valid_q || out_if.ready);

  // spill / refill between registers and memory
  assign wr_idx = count_q - CW'(2);
  assign rd_idx = count_q - CW'(3);
  assign mem_we = accept && (err_q == pfx_pkg::StatusOk) && !is_op
               && (count_q < CW'(STACK_DEPTH)) && (count_q >= CW'(2));
  assign mem_re = start_op && (count_q >= CW'(3));

  assign alu_req.start = start_op;
  assign alu_req.op    = op;
  assign alu_req.lhs   = nos_q;
  assign alu_req.rhs   = tos_q;

  pfx_serial_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfx_pkg::ST_IDLE: begin
        if (start_op) begin
          state_d = pfx_pkg::ST_EXEC;
        end else if (accept && in_if.last_symbol) begin
          state_d = pfx_pkg::ST_EMIT;
        end
      end
      pfx_pkg::ST_EXEC: begin
        if (alu_rsp.done) begin
          state_d = last_q ? pfx_pkg::ST_EMIT : pfx_pkg::ST_IDLE;
        end
      end
      pfx_pkg::ST_EMIT: begin
        if (emit_now) begin
          state_d = pfx_pkg::ST_IDLE;
        end
      end
      default: state_d = pfx_pkg::ST_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    count_d      = count_q;
    err_d        = err_q;
    tos_d        = tos_q;
    nos_d        = nos_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !out_if.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    in_if.ready  = (state_q == pfx_pkg::ST_IDLE);

    unique case (state_q)
      pfx_pkg::ST_IDLE: begin
        if (accept && (err_q == pfx_pkg::StatusOk)) begin
          last_d = in_if.last_symbol;
          if (is_op) begin
            if (count_q < CW'(2)) begin
              err_d = pfx_pkg::StatusUnderflow;
            end else if ((op == pfx_pkg::OP_DIV) && (tos_q == '0)) begin
              err_d = pfx_pkg::StatusDivZero;
            end
          end else if (count_q >= CW'(STACK_DEPTH)) begin
            err_d = pfx_pkg::StatusOverflow;
          end else begin
            nos_d   = tos_q;
            tos_d   = push_val;
            count_d = count_q + 1'b1;
          end
        end
      end
      pfx_pkg::ST_EXEC: begin
        if (alu_rsp.done) begin
          // two popped, one pushed
          tos_d   = alu_rsp.result;
          count_d = count_q - 1'b1;
          if (count_q >= CW'(3)) begin
            nos_d = rd_q;
          end
        end
      end
      pfx_pkg::ST_EMIT: begin
        if (emit_now) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          priority if (err_q != pfx_pkg::StatusOk) begin
            out_status_d = err_q;
          end else if (count_q == '0) begin
            out_status_d = pfx_pkg::StatusUnderflow;
          end else if (count_q > CW'(1)) begin
            out_status_d = pfx_pkg::StatusLeftover;
          end else begin
            out_status_d = pfx_pkg::StatusOk;
            out_value_d  = tos_q;
          end
          count_d = '0;
          err_d   = pfx_pkg::StatusOk;
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.result_value = out_value_q;
  assign out_if.status       = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfx_pkg::ST_IDLE;
      count_q     <= '0;
      err_q       <= pfx_pkg::StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q        <= tos_d;
    nos_q        <= nos_d;
    last_q       <= last_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  // value stack memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[wr_idx[AW-1:0]] <= nos_q;
    end
    if (mem_re) begin
      rd_q <= stack_mem[rd_idx[AW-1:0]];
    end
  end

endmodule
